/* sv/lsmr_pkg.sv */
`timescale 1ns / 1ps

package lsmr_pkg;

  // Widths of the channel fields and of the configuration port.
  localparam int IN_RANGE_W  = 16;
  localparam int OUT_RANGE_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int HALF_W_W    = 15;
  localparam int NUM_SECTORS = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_HALF_WIDTH  = 3'd2,
    CFG_MIN_RANGE   = 3'd3,
    CFG_MAX_RANGE   = 3'd4
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [15:0]         RST_FIRST_ANGLE = 16'h8000;
  localparam logic [15:0]         RST_ANGLE_STEP  = 16'd182;
  localparam logic [HALF_W_W-1:0] RST_HALF_WIDTH  = 15'd1820;
  localparam logic [15:0]         RST_MIN_RANGE   = 16'd120;
  localparam logic [15:0]         RST_MAX_RANGE   = 16'd12000;

  // Configuration register file contents, at the widths of the register map.
  typedef struct packed {
    logic [15:0]         first_angle;
    logic [15:0]         angle_step;
    logic [HALF_W_W-1:0] half_width;
    logic [15:0]         min_range;
    logic [15:0]         max_range;
  } cfg_regs_t;

endpackage

/* sv/lsmr_if.sv */
`timescale 1ns / 1ps

// Sample channel: one laser range sample per item.
interface lsmr_in_if;
  import lsmr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IN_RANGE_W-1:0] range_mm;
  logic                  not_finite;
  logic                  last_sample;

  modport source (output valid, output range_mm, output not_finite, output last_sample,
                  input ready);
  modport sink   (input valid, input range_mm, input not_finite, input last_sample,
                  output ready);
endinterface

// Result channel: the four sector minima of one scan per item.
interface lsmr_out_if;
  import lsmr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OUT_RANGE_W-1:0] front_mm;
  logic [OUT_RANGE_W-1:0] right_mm;
  logic [OUT_RANGE_W-1:0] left_mm;
  logic [OUT_RANGE_W-1:0] back_mm;

  modport source (output valid, output front_mm, output right_mm, output left_mm,
                  output back_mm, input ready);
  modport sink   (input valid, input front_mm, input right_mm, input left_mm,
                  input back_mm, output ready);
endinterface

/* sv/lsmr_cfg.sv */
`timescale 1ns / 1ps

module lsmr_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsmr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lsmr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lsmr_pkg::cfg_regs_t              regs
);
  import lsmr_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Decode a write into the addressed register; unknown indexes are dropped.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FIRST_ANGLE: regs_nxt.first_angle = cfg_data;
        CFG_ANGLE_STEP:  regs_nxt.angle_step  = cfg_data;
        CFG_HALF_WIDTH:  regs_nxt.half_width  = cfg_data[HALF_W_W-1:0];
        CFG_MIN_RANGE:   regs_nxt.min_range   = cfg_data;
        CFG_MAX_RANGE:   regs_nxt.max_range   = cfg_data;
        default:         regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.first_angle <= RST_FIRST_ANGLE;
      regs_r.angle_step  <= RST_ANGLE_STEP;
      regs_r.half_width  <= RST_HALF_WIDTH;
      regs_r.min_range   <= RST_MIN_RANGE;
      regs_r.max_range   <= RST_MAX_RANGE;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

/* sv/lsmr_sector.sv */
`timescale 1ns / 1ps

module lsmr_sector #(
  parameter int                    RANGE_BITS = 16,
  parameter int                    ANGLE_BITS = 16,
  parameter logic [ANGLE_BITS-1:0] CENTRE     = '0
) (
  input  logic [ANGLE_BITS-1:0]           angle,
  input  logic                            range_ok,
  input  logic [RANGE_BITS-1:0]           range_val,
  input  logic [lsmr_pkg::HALF_W_W-1:0]   half_width,
  input  logic [RANGE_BITS-1:0]           min_cur,
  input  logic                            hit_cur,
  output logic [RANGE_BITS-1:0]           min_nxt,
  output logic                            hit_nxt
);
  import lsmr_pkg::*;

  logic [ANGLE_BITS-1:0]          diff;
  logic [ANGLE_BITS-1:0]          mag;
  logic [ANGLE_BITS+HALF_W_W-1:0] mag_ext;
  logic [ANGLE_BITS+HALF_W_W-1:0] hw_ext;
  logic                           counts;

  // Wrapped difference to the sector centre, folded to its magnitude.
  // A half-turn difference folds onto itself and keeps the top bit set.
  assign diff = angle - CENTRE;
  assign mag  = diff[ANGLE_BITS-1] ? (~diff + {{(ANGLE_BITS-1){1'b0}}, 1'b1}) : diff;

  assign mag_ext = {{HALF_W_W{1'b0}}, mag};
  assign hw_ext  = {{ANGLE_BITS{1'b0}}, half_width};
  assign counts  = range_ok && (mag_ext <= hw_ext);

  // Keep the smallest counted range and note that the sector was hit.
  always_comb begin
    min_nxt = min_cur;
    hit_nxt = hit_cur;
    if (counts) begin
      hit_nxt = 1'b1;
      if (range_val < min_cur) begin
        min_nxt = range_val;
      end
    end
  end

endmodule

/* sv/lidar_sector_min_range_unit.sv */
`timescale 1ns / 1ps

// Nearest-obstacle finder for a laser scan. Each sample item carries a range in
// millimetres and is given a binary angle that starts at the first-sample angle
// register and grows by angle_step per sample (2^ANGLE_BITS units per turn). Four
// sectors centred front, right, left and back keep the smallest range within
// [min_range, max_range] whose wrapped angle lies within half_width of the centre;
// not-finite samples count nowhere but still advance the angle. The sample flagged
// last_sample ends the scan: one result item with the four minima follows
// (max_range for an empty sector) and the sector state and angle restart. The unit
// accepts one sample per clock; a last sample passes through the input register and
// then loads the result register. The rate is set by the update of the sector minima
// and the angle accumulator, which every sample reads and writes. A result
// waiting at the output does not stop samples of the next scan; only a second
// last sample stalls until the pending result is taken. Writing the first-sample
// angle reloads the angle at once; configure only while the unit is idle.
module lidar_sector_min_range_unit #(
  parameter int RANGE_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lsmr_in_if.sink                          in_ch,
  lsmr_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [lsmr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lsmr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsmr_pkg::*;

  localparam int SEC_FRONT = 0;
  localparam int SEC_RIGHT = 1;
  localparam int SEC_LEFT  = 2;
  localparam int SEC_BACK  = 3;

  localparam logic [ANGLE_BITS-1:0] CTR_FRONT = '0;
  localparam logic [ANGLE_BITS-1:0] CTR_LEFT  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] CTR_BACK  = {2'b10, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] CTR_RIGHT = {2'b11, {(ANGLE_BITS-2){1'b0}}};
  localparam logic [ANGLE_BITS-1:0] CENTRES [NUM_SECTORS] =
    '{CTR_FRONT, CTR_RIGHT, CTR_LEFT, CTR_BACK};

  cfg_regs_t regs;

  // Input register.
  logic                  s1_valid_r;
  logic [RANGE_BITS-1:0] s1_range_r;
  logic                  s1_bad_r;
  logic                  s1_last_r;

  // Scan state.
  logic [ANGLE_BITS-1:0] angle_r;
  logic [RANGE_BITS-1:0] min_r [NUM_SECTORS];
  logic                  hit_r [NUM_SECTORS];
  logic [RANGE_BITS-1:0] min_nxt [NUM_SECTORS];
  logic                  hit_nxt [NUM_SECTORS];

  // Result register.
  logic                   out_valid_r;
  logic [OUT_RANGE_W-1:0] out_mm_r [NUM_SECTORS];

  // Configuration widened or trimmed to the internal formats.
  logic [RANGE_BITS+IN_RANGE_W-1:0] in_range_ext;
  logic [RANGE_BITS+15:0]           min_rng_ext;
  logic [RANGE_BITS+15:0]           max_rng_ext;
  logic [ANGLE_BITS+15:0]           start_ext;
  logic [ANGLE_BITS+15:0]           step_ext;
  logic [ANGLE_BITS+CFG_DATA_W-1:0] load_ext;
  logic [RANGE_BITS-1:0]            min_rng;
  logic [RANGE_BITS-1:0]            max_rng;
  logic [ANGLE_BITS-1:0]            start_ang;
  logic [ANGLE_BITS-1:0]            step_ang;
  logic [ANGLE_BITS-1:0]            load_ang;
  logic                             start_load;

  logic in_fire;
  logic proc_fire;
  logic range_ok;

  // Fit an internal range value to the result field width.
  function automatic logic [OUT_RANGE_W-1:0] sector_out(input logic [RANGE_BITS-1:0] v);
    logic [RANGE_BITS+OUT_RANGE_W-1:0] ext;
    ext = {{OUT_RANGE_W{1'b0}}, v};
    return ext[OUT_RANGE_W-1:0];
  endfunction

  lsmr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .regs     (regs)
  );

  assign in_range_ext = {{RANGE_BITS{1'b0}}, in_ch.range_mm};
  assign min_rng_ext  = {{RANGE_BITS{1'b0}}, regs.min_range};
  assign max_rng_ext  = {{RANGE_BITS{1'b0}}, regs.max_range};
  assign start_ext    = {{ANGLE_BITS{1'b0}}, regs.first_angle};
  assign step_ext     = {{ANGLE_BITS{1'b0}}, regs.angle_step};
  assign load_ext     = {{ANGLE_BITS{1'b0}}, cfg_data};
  assign min_rng      = min_rng_ext[RANGE_BITS-1:0];
  assign max_rng      = max_rng_ext[RANGE_BITS-1:0];
  assign start_ang    = start_ext[ANGLE_BITS-1:0];
  assign step_ang     = step_ext[ANGLE_BITS-1:0];
  assign load_ang     = load_ext[ANGLE_BITS-1:0];
  assign start_load   = cfg_we && (cfg_idx == CFG_FIRST_ANGLE);

  // Handshake: the held sample moves on unless it is a last sample that
  // would overwrite a result nobody has taken yet.
  assign proc_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || proc_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_range_r <= in_range_ext[RANGE_BITS-1:0];
      s1_bad_r   <= in_ch.not_finite;
      s1_last_r  <= in_ch.last_sample;
    end
  end

  // Range gate shared by all sectors.
  assign range_ok = !s1_bad_r && (s1_range_r >= min_rng) && (s1_range_r <= max_rng);

  // One compare-and-keep unit per sector.
  for (genvar s = 0; s < NUM_SECTORS; s++) begin : g_sector
    lsmr_sector #(
      .RANGE_BITS (RANGE_BITS),
      .ANGLE_BITS (ANGLE_BITS),
      .CENTRE     (CENTRES[s])
    ) u_sector (
      .angle      (angle_r),
      .range_ok   (range_ok),
      .range_val  (s1_range_r),
      .half_width (regs.half_width),
      .min_cur    (min_r[s]),
      .hit_cur    (hit_r[s]),
      .min_nxt    (min_nxt[s]),
      .hit_nxt    (hit_nxt[s])
    );
  end

  // Scan state: update per sample, restart after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= start_ang;
      for (int s = 0; s < NUM_SECTORS; s++) begin
        min_r[s] <= '1;
        hit_r[s] <= 1'b0;
      end
    end else begin
      if (proc_fire) begin
        if (s1_last_r) begin
          angle_r <= start_ang;
          for (int s = 0; s < NUM_SECTORS; s++) begin
            min_r[s] <= '1;
            hit_r[s] <= 1'b0;
          end
        end else begin
          angle_r <= angle_r + step_ang;
          for (int s = 0; s < NUM_SECTORS; s++) begin
            min_r[s] <= min_nxt[s];
            hit_r[s] <= hit_nxt[s];
          end
        end
      end
      if (start_load) begin
        angle_r <= load_ang;
      end
    end
  end

  // Result register: loaded by a last sample, freed when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && s1_last_r) begin
      for (int s = 0; s < NUM_SECTORS; s++) begin
        out_mm_r[s] <= sector_out(hit_nxt[s] ? min_nxt[s] : max_rng);
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.front_mm = out_mm_r[SEC_FRONT];
  assign out_ch.right_mm = out_mm_r[SEC_RIGHT];
  assign out_ch.left_mm  = out_mm_r[SEC_LEFT];
  assign out_ch.back_mm  = out_mm_r[SEC_BACK];

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import lsmr_pkg::*;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 1000;
  localparam int NUM_REGS      = 5;
  localparam int SHOW_LIMIT    = 10;
  localparam int SCAN_PHASES   = 11;
  localparam int PHASE_SAMPLES = 150;

  typedef enum int {SEC_FRONT, SEC_RIGHT, SEC_LEFT, SEC_BACK} sector_t;

  // Index 0 is the front sector, then right, left and back.
  typedef logic [NUM_SECTORS-1:0][OUT_RANGE_W-1:0] minima_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lsmr_in_if  in_ch ();
  lsmr_out_if out_ch ();

  lidar_sector_min_range_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the register file and of the scan state.
  logic [15:0]          shadow_start;
  logic [15:0]          shadow_step;
  logic [HALF_W_W-1:0]  shadow_half;
  logic [15:0]          shadow_lo;
  logic [15:0]          shadow_hi;
  logic [15:0]          scan_angle;
  minima_t              nearest_mm;
  logic [NUM_SECTORS-1:0] sector_seen;

  // Sector minima still owed by the block, oldest first.
  minima_t owed_minima[$];

  int fail_count   = 0;
  int idle_pct     = 25;
  int stall_left   = 0;
  int quiet_cycles = 0;

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  function automatic logic [15:0] sector_centre(sector_t s);
    case (s)
      SEC_FRONT: return 16'h0000;
      SEC_RIGHT: return 16'hC000;
      SEC_LEFT:  return 16'h4000;
      default:   return 16'h8000;
    endcase
  endfunction

  // The wrapped signed difference to the centre, taken as a magnitude.
  function automatic bit in_sector(logic [15:0] angle, sector_t s);
    logic [15:0] diff;
    logic [16:0] span;
    diff = angle - sector_centre(s);
    span = diff[15] ? 17'h10000 - 17'(diff) : 17'(diff);
    return span <= 17'(shadow_half);
  endfunction

  function automatic void restart_scan();
    nearest_mm  = '1;
    sector_seen = '0;
    scan_angle  = shadow_start;
  endfunction

  // Update the sector minima with one accepted sample; a last sample closes the scan.
  function automatic void absorb_sample(logic [15:0] r, logic nf, logic last);
    bit      counts;
    minima_t report;
    counts = !nf && r >= shadow_lo && r <= shadow_hi;
    for (int s = 0; s < NUM_SECTORS; s++) begin
      if (counts && in_sector(scan_angle, sector_t'(s))) begin
        if (r < nearest_mm[s]) nearest_mm[s] = r;
        sector_seen[s] = 1'b1;
      end
    end
    scan_angle = scan_angle + shadow_step;
    if (last) begin
      for (int s = 0; s < NUM_SECTORS; s++)
        report[s] = sector_seen[s] ? nearest_mm[s] : shadow_hi;
      owed_minima.push_back(report);
      restart_scan();
    end
  endfunction

  // Mostly no gap, some short ones and now and then a long one.
  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // A setting that is one of two extremes, fully random, or inside a usual span.
  function automatic logic [15:0] pick_word(logic [15:0] ext_a, logic [15:0] ext_b,
                                            int unsigned lo, int unsigned hi);
    case ($urandom_range(7))
      0:       return ext_a;
      1:       return ext_b;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // Ranges land inside the accepted window most of the time.
  function automatic logic [15:0] pick_range();
    if (shadow_lo <= shadow_hi && $urandom_range(3) != 0)
      return 16'($urandom_range(shadow_hi, shadow_lo));
    return 16'($urandom);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  // Send one sample item and fold it into the shadow state once it is taken.
  task automatic send_sample(logic [15:0] r, logic nf, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.range_mm    <= r;
    in_ch.not_finite  <= nf;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_sample(r, nf, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FIRST_ANGLE: begin
        shadow_start = value;
        scan_angle   = value;
      end
      CFG_ANGLE_STEP:  shadow_step = value;
      CFG_HALF_WIDTH:  shadow_half = value[HALF_W_W-1:0];
      CFG_MIN_RANGE:   shadow_lo = value;
      CFG_MAX_RANGE:   shadow_hi = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] start, logic [15:0] step, logic [15:0] half,
                               logic [15:0] lo, logic [15:0] hi);
    write_reg(CFG_FIRST_ANGLE, start);
    write_reg(CFG_ANGLE_STEP, step);
    write_reg(CFG_HALF_WIDTH, half);
    write_reg(CFG_MIN_RANGE, lo);
    write_reg(CFG_MAX_RANGE, hi);
  endtask

  // Let every owed result arrive and samples still in flight settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (owed_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One sample at the reset settings lands on the back centre.
  task automatic test_reset_state();
    send_sample(16'd500, 1'b0, 1'b1);
  endtask

  // Quarter-turn steps put one sample on each centre, with extreme ranges.
  task automatic test_sector_centres();
    wait_idle();
    load_settings(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(16'd1, 1'b0, 1'b0);
    send_sample(16'hFFFE, 1'b0, 1'b1);
  endtask

  // Non-finite readings count nowhere but still move the angle on.
  task automatic test_not_finite();
    send_sample(16'd10, 1'b1, 1'b0);
    send_sample(16'd20, 1'b0, 1'b0);
    send_sample(16'd30, 1'b1, 1'b0);
    send_sample(16'd40, 1'b0, 1'b1);
  endtask

  // With the minimum above the maximum nothing counts.
  task automatic test_inverted_bounds();
    wait_idle();
    write_reg(CFG_MIN_RANGE, 16'd200);
    write_reg(CFG_MAX_RANGE, 16'd100);
    send_sample(16'd150, 1'b0, 1'b0);
    send_sample(16'd100, 1'b0, 1'b1);
  endtask

  // A difference of exactly half a turn stays outside the widest sector.
  task automatic test_half_turn();
    wait_idle();
    load_settings(16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_sample(16'd300, 1'b0, 1'b1);
    wait_idle();
    write_reg(CFG_FIRST_ANGLE, 16'h0000);
    send_sample(16'd400, 1'b0, 1'b1);
  endtask

  // Rewriting the first-sample angle mid-scan moves the angle but keeps the minima.
  task automatic test_start_reload();
    wait_idle();
    load_settings(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'd700, 1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_FIRST_ANGLE, 16'hC000);
    send_sample(16'd800, 1'b0, 1'b1);
  endtask

  // Writes to indexes past the register map change nothing.
  task automatic test_unknown_index();
    wait_idle();
    for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++) write_reg(CFG_IDX_W'(i), 16'hFFFF);
    send_sample(16'd900, 1'b0, 1'b1);
  endtask

  // Ranges just outside and exactly on both bounds.
  task automatic test_range_bounds();
    wait_idle();
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'd1000, 16'd2000);
    send_sample(16'd999, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b1);
    send_sample(16'd2001, 1'b0, 1'b0);
    send_sample(16'd2000, 1'b0, 1'b1);
  endtask

  // The angle runs backwards through zero and wraps.
  task automatic test_angle_wrap();
    wait_idle();
    load_settings(16'h0001, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF);
    send_sample(16'd50, 1'b0, 1'b0);
    send_sample(16'd40, 1'b0, 1'b0);
    send_sample(16'd30, 1'b0, 1'b0);
    send_sample(16'd20, 1'b0, 1'b1);
  endtask

  // Phases of random settings, each feeding scans of random length and content.
  task automatic test_random_scans();
    int          sent;
    int          scan_len;
    logic [15:0] lo;
    logic [15:0] hi;
    for (int p = 0; p < SCAN_PHASES; p++) begin
      wait_idle();
      idle_pct = (p % 4 == 1) ? 0 : 30;
      case ($urandom_range(5))
        0: begin
          lo = 16'h0000;
          hi = 16'hFFFF;
        end
        1: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
        end
        default: begin
          lo = 16'($urandom_range(2000));
          hi = 16'($urandom_range(65535, 3000));
        end
      endcase
      load_settings(pick_word(16'h8000, 16'h7FFF, 0, 65535),
                    pick_word(16'h0000, 16'hFFFF, 1000, 16000),
                    pick_word(16'h0000, 16'hFFFF, 300, 9000), lo, hi);
      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        scan_len = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
        // A scan now and then loses its closing flag and runs into the next one.
        for (int k = 0; k < scan_len; k++)
          send_sample(pick_range(), $urandom_range(9) == 0,
                      k == scan_len - 1 && $urandom_range(19) != 0);
        sent += scan_len;
      end
    end
  endtask

  // Compare each result item with the oldest owed one, then pick the next ready.
  always @(posedge clk) begin
    minima_t got;
    minima_t want;
    sector_t which;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.back_mm, out_ch.left_mm, out_ch.right_mm, out_ch.front_mm};
      if (owed_minima.size() == 0) begin
        note_failure($sformatf("unexpected result front %0d right %0d left %0d back %0d",
                               got[SEC_FRONT], got[SEC_RIGHT], got[SEC_LEFT], got[SEC_BACK]));
      end else begin
        want = owed_minima.pop_front();
        for (int s = 0; s < NUM_SECTORS; s++) begin
          which = sector_t'(s);
          if (got[s] !== want[s])
            note_failure($sformatf("%s expected %0d, got %0d", which.name(), want[s], got[s]));
        end
      end
    end
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.range_mm    = '0;
    in_ch.not_finite  = 1'b0;
    in_ch.last_sample = 1'b0;
    out_ch.ready      = 1'b0;
    shadow_start = RST_FIRST_ANGLE;
    shadow_step  = RST_ANGLE_STEP;
    shadow_half  = RST_HALF_WIDTH;
    shadow_lo    = RST_MIN_RANGE;
    shadow_hi    = RST_MAX_RANGE;
    restart_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_sector_centres();
    test_not_finite();
    test_inverted_bounds();
    test_half_turn();
    test_start_reload();
    test_unknown_index();
    test_range_bounds();
    test_angle_wrap();
    test_random_scans();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_minima.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* lidar_sector_min_range_unit.f */
sv/lsmr_pkg.sv
sv/lsmr_if.sv
sv/lsmr_cfg.sv
sv/lsmr_sector.sv
sv/lidar_sector_min_range_unit.sv
test/tb.sv
